[rtl/kab_pkg.sv]
// kab_pkg: types, constants and helpers shared by the k-th ancestor core.
// Holds the jump-table geometry, the mode codes, the sequencer states and beat structs.
// No dependencies.
package kab_pkg;

    // Tree and jump-table geometry
    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 11;
    localparam int NODE_W    = 11;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int TBL_DEPTH = LEVELS * MAX_NODES;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    // Stream and register port widths
    localparam int MODE_W     = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map (index into the register list, byte address is 4*index)
    localparam logic [0:0] REG_NODE_COUNT = 1'b0;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_QUERY = 2'd2
    } kab_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BINIT,
        ST_BRD1,
        ST_BRD2,
        ST_BWR,
        ST_QCHK,
        ST_QSCAN,
        ST_QWAIT,
        ST_RESP
    } kab_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] boss;
        logic [NODE_W-1:0] steps;
    } kab_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              found;
    } kab_result_t;

    // Table address of entry (level, node); node runs from 1
    function automatic logic [ADDR_W-1:0] kab_addr(input logic [LVL_W-1:0]  lvl,
                                                  input logic [NODE_W-1:0] nd);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(nd - NODE_W'(1));
        return ADDR_W'(int'(lvl) * MAX_NODES + int'(idx));
    endfunction

endpackage

[rtl/kab_ram.sv]
// kab_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/kab_engine.sv]
// kab_engine: sequencer for loads, table build and ancestor queries.
// Drives the jump-table RAM (kab_ram) one entry at a time. Depends on kab_pkg.
module kab_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  kab_pkg::kab_item_t          in_item,
    input  logic                        cfg_wr,
    input  logic [kab_pkg::NODE_W-1:0]  act_cnt,
    output logic                        res_valid,
    input  logic                        res_ready,
    output kab_pkg::kab_result_t        res
);
    import kab_pkg::*;

    kab_state_t        state_reg, state_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [NODE_W-1:0] v_reg, v_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] steps_reg, steps_next;
    logic              built_reg, built_next;
    kab_result_t       res_reg, res_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [NODE_W-1:0] wdata, rdata;
    logic              accept;
    logic              rd_ok;
    logic              last_v;
    logic              last_lvl;
    logic              bad_start;

    kab_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign accept    = in_valid && in_ready;
    // shared range compare on whatever the table returned
    assign rd_ok     = (rdata != '0) && (rdata <= act_cnt);
    assign last_v    = (v_reg == act_cnt);
    assign last_lvl  = (lvl_reg == LVL_W'(LEVELS - 1));
    assign bad_start = !built_reg || (cur_reg == '0) || (cur_reg > act_cnt)
                       || ((steps_reg >> LEVELS) != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_item.mode)
                        MODE_BUILD: state_next = ST_BINIT;
                        MODE_QUERY: state_next = ST_QCHK;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BINIT: state_next = (act_cnt == '0) ? ST_IDLE : ST_BRD1;
            ST_BRD1:  state_next = ST_BRD2;
            ST_BRD2: begin
                if (rd_ok) begin
                    state_next = ST_BWR;
                end else if (last_v && last_lvl) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_BRD1;
                end
            end
            ST_BWR:   state_next = (last_v && last_lvl) ? ST_IDLE : ST_BRD1;
            ST_QCHK:  state_next = bad_start ? ST_RESP : ST_QSCAN;
            ST_QSCAN: begin
                if (lvl_reg == LVL_W'(LEVELS)) begin
                    state_next = ST_RESP;
                end else if (steps_reg[lvl_reg]) begin
                    state_next = ST_QWAIT;
                end
            end
            ST_QWAIT: state_next = rd_ok ? ST_QSCAN : ST_RESP;
            ST_RESP:  state_next = res_ready ? ST_IDLE : ST_RESP;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: handshakes and RAM port control
    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_RESP);
        we        = 1'b0;
        waddr     = kab_addr(lvl_reg, v_reg);
        wdata     = '0;
        raddr     = kab_addr(lvl_reg, cur_reg);
        unique case (state_reg)
            ST_IDLE: begin
                // parent load goes straight into level 0
                waddr = kab_addr('0, in_item.node);
                wdata = (in_item.boss <= act_cnt) ? in_item.boss : '0;
                we    = accept && (in_item.mode == MODE_LOAD)
                        && (in_item.node >= NODE_W'(2)) && (in_item.node <= act_cnt);
            end
            ST_BINIT: begin
                waddr = kab_addr('0, NODE_W'(1));
                we    = (act_cnt != '0);
            end
            ST_BRD1: begin
                raddr = kab_addr(lvl_reg - LVL_W'(1), v_reg);
            end
            ST_BRD2: begin
                // mid is in range: fetch its entry, else the jump is none
                raddr = kab_addr(lvl_reg - LVL_W'(1), rdata);
                we    = !rd_ok;
            end
            ST_BWR: begin
                we    = 1'b1;
                wdata = rdata;
            end
            default: ;
        endcase
    end

    // datapath registers
    always_comb begin
        lvl_next   = lvl_reg;
        v_next     = v_reg;
        cur_next   = cur_reg;
        steps_next = steps_reg;
        built_next = built_reg;
        res_next   = res_reg;
        if (cfg_wr) begin
            built_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_item.mode == MODE_LOAD) begin
                    built_next = 1'b0;
                end
                cur_next   = in_item.node;
                steps_next = in_item.steps;
                lvl_next   = LVL_W'(1);
                v_next     = NODE_W'(1);
            end
            ST_BINIT: begin
                if (act_cnt == '0) begin
                    built_next = 1'b1;
                end
            end
            ST_BRD2, ST_BWR: begin
                if ((state_reg == ST_BWR) || !rd_ok) begin
                    if (last_v) begin
                        v_next   = NODE_W'(1);
                        lvl_next = lvl_reg + LVL_W'(1);
                        if (last_lvl) begin
                            built_next = 1'b1;
                        end
                    end else begin
                        v_next = v_reg + NODE_W'(1);
                    end
                end
            end
            ST_QCHK: begin
                lvl_next     = '0;
                res_next     = '0;
            end
            ST_QSCAN: begin
                if (lvl_reg == LVL_W'(LEVELS)) begin
                    res_next.ancestor = cur_reg;
                    res_next.found    = 1'b1;
                end else if (!steps_reg[lvl_reg]) begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            ST_QWAIT: begin
                cur_next = rdata;
                lvl_next = lvl_reg + LVL_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            built_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            built_reg <= built_next;
        end
        lvl_reg   <= lvl_next;
        v_reg     <= v_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

[rtl/kth_ancestor_binary_lifting_core.sv]
// kth_ancestor_binary_lifting_core: top level of the k-th ancestor unit.
// APB register, stream ports and output register around kab_engine. Depends on kab_pkg.
//
//  Port group   Direction  Beat contents
//  s_*          in         tuser: mode; tdata: node, boss, steps
//  m_*          out        tuser: found; tdata: ancestor (queries only)
//  APB          in/out     register 0 at 0x0: node_count
//
// A parent load is written into level 0 as it is taken. A query holds the core while it
// scans each level and reads the table once per set bit of steps, ending early on a fail.
// A build fills the table one entry per pass, over every active node at each level above 0.
// Reset is synchronous; the table holds no reset value and must be loaded and built.
// A waiting result sits in the output register; the next item is taken meanwhile,
// and a later query waits only if the register is still full when it finishes.
module kth_ancestor_binary_lifting_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kab_pkg::S_TDATA_W-1:0]      s_tdata,  // node, boss, steps
    input  logic [kab_pkg::MODE_W-1:0]         s_tuser,  // mode
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kab_pkg::M_TDATA_W-1:0]      m_tdata,  // ancestor
    output logic                               m_tuser,  // found
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kab_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [kab_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [kab_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import kab_pkg::*;

    logic [NODE_W-1:0] node_count_reg, node_count_next;
    logic              m_valid_reg, m_valid_next;
    kab_result_t       m_res_reg, m_res_next;

    logic              cfg_wr;
    logic [NODE_W-1:0] act_cnt;
    kab_item_t         item;
    logic              res_valid;
    logic              res_ready;
    kab_result_t       res;

    // register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DATA_W'(node_count_reg) : '0;
    assign node_count_next = cfg_wr ? pwdata[NODE_W-1:0] : node_count_reg;

    // nodes in use, capped at the table size
    assign act_cnt = (node_count_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                           : node_count_reg;

    // unpack input beat
    assign item.mode  = s_tuser;
    assign item.node  = s_tdata[NODE_W-1:0];
    assign item.boss  = s_tdata[2*NODE_W-1:NODE_W];
    assign item.steps = s_tdata[3*NODE_W-1:2*NODE_W];

    kab_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .cfg_wr    (cfg_wr),
        .act_cnt   (act_cnt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            node_count_reg <= node_count_next;
            m_valid_reg    <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_res_reg.ancestor);
    assign m_tuser  = m_res_reg.found;

endmodule

[rtl/kab_checker.sv]
// kab_checker: port-level assertions for kth_ancestor_binary_lifting_core, and its bind.
// Depends on kab_pkg and the top level.
module kab_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [kab_pkg::MODE_W-1:0]         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [kab_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               m_tuser
);
    import kab_pkg::*;

    // no result beat straight after reset
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // not found always carries ancestor zero
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found beat with non-zero ancestor");

    // a found ancestor is a real node
    a_found_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata != '0 && m_tdata <= M_TDATA_W'(MAX_NODES))
        else $error("found beat with ancestor outside the node range");

    // a build beat takes the core busy
    a_build_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_BUILD |=> !s_tready)
        else $error("input ready straight after a build beat");

endmodule

bind kth_ancestor_binary_lifting_core kab_checker u_kab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
